[hdl/rational_fraction_alu_top_defines.svh]
// Assertion macros shared by the rational fraction ALU modules.
`ifndef RATIONAL_FRACTION_ALU_TOP_DEFINES_SVH
`define RATIONAL_FRACTION_ALU_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RFA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define RFA_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define RFA_ASSERT(label, clk, rst_n, prop)
`define RFA_ASSERT_NR(label, clk, prop)
`endif
`endif

[hdl/rfa_pkg.sv]
// Types and constants of the rational fraction ALU.
`timescale 1ns / 1ps
package rfa_pkg;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int MAG_W = 65;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]       status;
        logic             neg;
        logic [MAG_W-1:0] n_mag;
        logic [MAG_W-1:0] d_mag;
    } rfa_job_t;

    typedef struct packed {
        logic [NUM_W-1:0] result_num;
        logic [DEN_W-1:0] result_den;
        logic [1:0]       status;
    } rfa_res_t;
endpackage

[hdl/rfa_if.sv]
// Valid/ready channel interfaces for the fraction ALU.
`timescale 1ns / 1ps
interface rfa_in_if #(parameter int OPERAND_WIDTH = 16) (input logic clk);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic signed [OPERAND_WIDTH-1:0] num_a;
    logic signed [OPERAND_WIDTH-1:0] den_a;
    logic signed [OPERAND_WIDTH-1:0] num_b;
    logic signed [OPERAND_WIDTH-1:0] den_b;
    modport source (output valid, operation, num_a, den_a, num_b, den_b, input ready);
    modport sink (input valid, operation, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rfa_out_if (input logic clk);
    logic               valid;
    logic               ready;
    logic signed [32:0] result_num;
    logic [30:0]        result_den;
    logic [1:0]         status;
    modport source (output valid, result_num, result_den, status, input ready);
    modport sink (input valid, result_num, result_den, status, output ready);
endinterface

[hdl/rfa_front.sv]
// Front end: accept a transaction, form cross products, classify errors.
`timescale 1ns / 1ps
module rfa_front #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rfa_in_if.sink               in_ch,
    output rfa_pkg::rfa_job_t    job,
    output logic                 job_valid,
    input  logic                 job_ready
);
    import rfa_pkg::*;
    localparam int W = OPERAND_WIDTH;
    localparam int P = 2 * W;

    // stage 1: magnitudes; stage 2: products; stage 3: sum
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] op_reg;
    logic [W:0] na_reg, da_reg, nb_reg, db_reg;
    logic sna_reg, sda_reg, snb_reg, sdb_reg;
    logic [P-1:0] p1_reg, p2_reg, pd_reg;
    logic s1_reg, s2_reg, sd_reg;
    rfa_job_t job_reg, job_next;

    function automatic logic [W:0] mag_of(input logic [W-1:0] v);
        logic [W:0] e;
        e = {v[W-1], v};
        mag_of = v[W-1] ? (~e + 1'b1) : e;
    endfunction

    assign in_ch.ready = (state_reg == S_IDLE);
    assign job = job_reg;
    assign job_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_ch.valid) state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_OUT;
            S_OUT:  if (job_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        logic [MAG_W-1:0] a, b, nm, dm;
        logic ns, ds;
        a = MAG_W'(p1_reg);
        b = MAG_W'(p2_reg);
        ds = sd_reg;
        dm = MAG_W'(pd_reg);
        if (op_reg == OP_ADD || op_reg == OP_SUB)
        begin
            if (s1_reg == s2_reg)
            begin
                nm = a + b; ns = s1_reg;
            end
            else if (a >= b)
            begin
                nm = a - b; ns = s1_reg;
            end
            else
            begin
                nm = b - a; ns = s2_reg;
            end
        end
        else
        begin
            nm = a; ns = s1_reg;
        end
        job_next.n_mag = nm;
        job_next.d_mag = dm;
        job_next.neg = (nm != '0) && (ns != ds);
        if (da_reg == '0 || db_reg == '0)
            job_next.status = ST_ZERO_DEN;
        else if (op_reg == OP_DIV && nb_reg == '0)
            job_next.status = ST_DIV_ZERO;
        else
            job_next.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            op_reg  <= in_ch.operation;
            na_reg  <= mag_of(in_ch.num_a);
            da_reg  <= mag_of(in_ch.den_a);
            nb_reg  <= mag_of(in_ch.num_b);
            db_reg  <= mag_of(in_ch.den_b);
            sna_reg <= in_ch.num_a[W-1];
            sda_reg <= in_ch.den_a[W-1];
            snb_reg <= in_ch.num_b[W-1];
            sdb_reg <= in_ch.den_b[W-1];
        end
        if (state_reg == S_MUL)
        begin
            p2_reg <= P'(op_reg == OP_MUL ? nb_reg * da_reg : nb_reg * da_reg);
            if (op_reg == OP_MUL)
            begin
                p1_reg <= P'(na_reg * nb_reg);
                s1_reg <= sna_reg ^ snb_reg;
            end
            else
            begin
                p1_reg <= P'(na_reg * db_reg);
                s1_reg <= sna_reg ^ sdb_reg;
            end
            s2_reg <= snb_reg ^ sda_reg ^ (op_reg == OP_SUB);
            if (op_reg == OP_DIV)
            begin
                pd_reg <= P'(da_reg * nb_reg);
                sd_reg <= sda_reg ^ snb_reg;
            end
            else
            begin
                pd_reg <= P'(da_reg * db_reg);
                sd_reg <= sda_reg ^ sdb_reg;
            end
        end
        if (state_reg == S_SUM)
            job_reg <= job_next;
    end

`include "rational_fraction_alu_top_defines.svh"
    `RFA_ASSERT(a_front_hold, clk, rst_n, (job_valid && !job_ready) |=> $stable(job))
    `RFA_ASSERT(a_front_busy, clk, rst_n, (state_reg != S_IDLE) |-> !in_ch.ready)
    `RFA_ASSERT(a_front_seq, clk, rst_n, (state_reg == S_MUL) |=> (state_reg == S_SUM))
endmodule

[hdl/rfa_queue.sv]
// Two-entry queue between front and back ends.
`timescale 1ns / 1ps
module rfa_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  rfa_pkg::rfa_job_t wr_data,
    input  logic              wr_valid,
    output logic              wr_ready,
    output rfa_pkg::rfa_job_t rd_data,
    output logic              rd_valid,
    input  logic              rd_ready
);
    import rfa_pkg::*;
    rfa_job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr_en, rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rp_reg];
    assign wr_en = wr_valid && wr_ready;
    assign rd_en = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

`include "rational_fraction_alu_top_defines.svh"
    `RFA_ASSERT(a_q_bound, clk, rst_n, cnt_reg <= 2'd2)
    `RFA_ASSERT(a_q_ptr, clk, rst_n, (cnt_reg == 2'd1) |-> (wp_reg != rp_reg))
    `RFA_ASSERT(a_q_empty, clk, rst_n, ((cnt_reg == 2'd0) || (cnt_reg == 2'd2)) |-> (wp_reg == rp_reg))
endmodule

[hdl/rfa_back.sv]
// Back end: binary GCD, two restoring divisions, output register.
`timescale 1ns / 1ps
module rfa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rfa_pkg::rfa_job_t job,
    input  logic              job_valid,
    output logic              job_ready,
    rfa_out_if.source         out_ch
);
    import rfa_pkg::*;
    localparam int CW = $clog2(MAG_W + 1);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_GCD  = 3'd1;
    localparam logic [2:0] B_DIVN = 3'd2;
    localparam logic [2:0] B_DIVD = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    logic [2:0] st_reg;
    logic [MAG_W-1:0] u_reg, v_reg, g_reg, n_reg, d_reg, q_reg, r_reg, rn_reg;
    logic [CW-1:0] k_reg, i_reg;
    logic neg_reg;
    rfa_res_t res_reg;
    logic [MAG_W:0] rs;
    logic [MAG_W-1:0] dv, gsh;
    logic [CW-1:0] bit_idx;
    logic q_bit;

    assign job_ready = (st_reg == B_IDLE);
    assign out_ch.valid = (st_reg == B_OUT);
    assign out_ch.result_num = res_reg.result_num;
    assign out_ch.result_den = res_reg.result_den;
    assign out_ch.status = res_reg.status;

    assign dv = (st_reg == B_DIVN) ? n_reg : d_reg;
    assign bit_idx = CW'(MAG_W - 1) - i_reg;
    assign rs = {r_reg, dv[bit_idx]};
    assign q_bit = (rs >= {1'b0, g_reg});
    assign gsh = u_reg << k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= B_IDLE;
        else
        begin
            case (st_reg)
                B_IDLE:
                    if (job_valid)
                        st_reg <= (job.status != ST_OK || job.n_mag == '0) ? B_OUT : B_GCD;
                B_GCD:
                    if (u_reg == v_reg) st_reg <= B_DIVN;
                B_DIVN:
                    if (i_reg == CW'(MAG_W - 1)) st_reg <= B_DIVD;
                B_DIVD:
                    if (i_reg == CW'(MAG_W - 1)) st_reg <= B_OUT;
                B_OUT:
                    if (out_ch.ready) st_reg <= B_IDLE;
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    // Binary GCD: strip common twos, then subtract-and-shift on odd values.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            B_IDLE:
                if (job_valid)
                begin
                    n_reg <= job.n_mag;
                    d_reg <= job.d_mag;
                    u_reg <= job.n_mag;
                    v_reg <= job.d_mag;
                    k_reg <= '0;
                    neg_reg <= job.neg;
                    res_reg.result_num <= '0;
                    res_reg.result_den <= DEN_W'(1);
                    res_reg.status <= job.status;
                end
            B_GCD:
            begin
                // both values stay nonzero, so equal values end the loop
                if (u_reg == v_reg)
                begin
                    g_reg <= gsh;
                    i_reg <= '0;
                    r_reg <= '0;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else if (u_reg >= v_reg)
                    u_reg <= (u_reg - v_reg) >> 1;
                else
                    v_reg <= (v_reg - u_reg) >> 1;
            end
            B_DIVN, B_DIVD:
            begin
                q_reg <= {q_reg[MAG_W-2:0], q_bit};
                if (i_reg == CW'(MAG_W - 1))
                begin
                    i_reg <= '0;
                    r_reg <= '0;
                    if (st_reg == B_DIVN)
                        rn_reg <= {q_reg[MAG_W-2:0], q_bit};
                    else
                    begin
                        res_reg.result_num <= neg_reg ? NUM_W'(~rn_reg + 1'b1) : NUM_W'(rn_reg);
                        res_reg.result_den <= DEN_W'({q_reg[MAG_W-2:0], q_bit});
                    end
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                    r_reg <= q_bit ? MAG_W'(rs - {1'b0, g_reg}) : MAG_W'(rs);
                end
            end
            default: ;
        endcase
    end

`include "rational_fraction_alu_top_defines.svh"
    `RFA_ASSERT(a_back_hold, clk, rst_n, (out_ch.valid && !out_ch.ready) |=> $stable(res_reg))
    `RFA_ASSERT(a_back_den, clk, rst_n, out_ch.valid |-> (out_ch.result_den != '0))
    `RFA_ASSERT(a_back_err, clk, rst_n, (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.result_num == '0))
endmodule

[hdl/rational_fraction_alu_top.sv]
// Top level of the rational fraction ALU.
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    operation, num_a, den_a, num_b, den_b
//   out_ch    out   valid/ready    result_num, result_den, status
// A transaction passes the front-end states (capture, products, sum, output),
// the queue, and the back end: binary GCD steps until the two values match, then
// two restoring divisions of 65 quotient bits each and the output register.
// Error and zero results skip the GCD and the divisions in the back end.
// Reset is asynchronous, active low, and clears the state machines and the queue pointers and count.
// A two-entry queue lets the front end take work while the back end stalls.
`timescale 1ns / 1ps
module rational_fraction_alu_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    rfa_in_if.sink    in_ch,
    rfa_out_if.source out_ch
);
    import rfa_pkg::*;
    rfa_job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    rfa_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
    );

    rfa_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_data(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    rfa_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
        .out_ch(out_ch)
    );
endmodule

[tb/sv/rfa_checker.sv]
// Scoreboard for the rational fraction ALU: predicts each result and compares it.
`timescale 1ns / 1ps
module rfa_checker (
    input  logic   clk,
    input  logic   rst_n,
    rfa_in_if.sink in_mon,
    rfa_out_if.sink out_mon,
    output int     fail_count,
    output int     pending_count
);
    import rfa_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [1:0]       status;
    } fraction_t;

    fraction_t expected_fractions[$];

    function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Full-width signed arithmetic: 16-bit operands keep every product within 64 bits.
    function automatic fraction_t reduce_fraction(logic [1:0] op, longint na, longint da,
                                                  longint nb, longint db);
        fraction_t r;
        longint n, d;
        longint unsigned nm, dm, g;
        logic neg;
        r.num = '0;
        r.den = DEN_W'(1);
        r.status = ST_OK;
        if (da == 0 || db == 0)
        begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        if (op == OP_DIV && nb == 0)
        begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        case (op)
            OP_ADD: begin n = na * db + nb * da; d = da * db; end
            OP_SUB: begin n = na * db - nb * da; d = da * db; end
            OP_MUL: begin n = na * nb; d = da * db; end
            default: begin n = na * db; d = da * nb; end
        endcase
        if (n == 0)
            return r;
        neg = (n < 0) != (d < 0);
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        g = euclid_gcd(nm, dm);
        nm = nm / g;
        dm = dm / g;
        r.num = neg ? (NUM_W'(0) - NUM_W'(nm)) : NUM_W'(nm);
        r.den = DEN_W'(dm);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending_count = expected_fractions.size();

    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n && in_mon.valid && in_mon.ready)
            expected_fractions.push_back(reduce_fraction(in_mon.operation, in_mon.num_a,
                in_mon.den_a, in_mon.num_b, in_mon.den_b));
        if (rst_n && out_mon.valid && out_mon.ready)
        begin
            if (expected_fractions.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding", $realtime);
                fail_count++;
            end
            else
            begin
                want = expected_fractions.pop_front();
                if (out_mon.result_num !== want.num)
                    report_mismatch("result_num", out_mon.result_num, $signed(want.num));
                if (out_mon.result_den !== want.den)
                    report_mismatch("result_den", out_mon.result_den, want.den);
                if (out_mon.status !== want.status)
                    report_mismatch("status", out_mon.status, want.status);
            end
        end
    end
endmodule

[tb/sv/testbench.sv]
// Top of the rational fraction ALU testbench: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;
    import rfa_pkg::*;

    localparam int RANDOM_ITEMS = 1230;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending_count;
    int   hold_off = 0;
    bit   random_stalls = 1'b0;

    rfa_in_if #(.OPERAND_WIDTH(16)) in_ch (clk);
    rfa_out_if out_ch (clk);

    rational_fraction_alu_top #(.OPERAND_WIDTH(16)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
    );

    rfa_checker i_checker (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.operation = OP_ADD;
        in_ch.num_a = '0;
        in_ch.den_a = 16'sd1;
        in_ch.num_b = '0;
        in_ch.den_b = 16'sd1;
        out_ch.ready = 1'b0;
    end

    // Receiver: forced hold-off first, otherwise a stall pattern with calm stretches.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end
        else if (random_stalls)
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            out_ch.ready <= 1'b1;
    end

    always
    begin
        repeat ($urandom_range(50, 400)) @(posedge clk);
        random_stalls = ~random_stalls;
    end

    function automatic logic [15:0] edge_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h0001;
            4: return 16'hffff;
            5: return 16'(16'sd0 - 16'($urandom_range(1, 12)));
            6: return 16'($urandom_range(1, 12));
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one transaction and hold it until accepted.
    task automatic send_fraction(logic [1:0] op, logic [15:0] na, logic [15:0] da,
                                 logic [15:0] nb, logic [15:0] db);
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.num_a <= na;
        in_ch.den_a <= da;
        in_ch.num_b <= nb;
        in_ch.den_b <= db;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        idle_sender(1);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int burst;
        logic [15:0] fa, fb, fc, fd;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fraction(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_fraction(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_fraction(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
        send_fraction(OP_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_fraction(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8001);
        send_fraction(OP_SUB, 16'h8000, 16'h0001, 16'h7fff, 16'h0001);
        send_fraction(OP_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
        send_fraction(OP_DIV, 16'h8000, 16'h0001, 16'h0001, 16'h7fff);
        send_fraction(OP_ADD, 16'd3, 16'd0, 16'd1, 16'd1);
        send_fraction(OP_DIV, 16'd3, 16'd1, 16'd1, 16'd0);
        send_fraction(OP_DIV, 16'd0, 16'd0, 16'd0, 16'd5);
        send_fraction(OP_DIV, 16'd5, 16'd7, 16'd0, 16'd9);
        send_fraction(OP_MUL, 16'd0, 16'hfffd, 16'd4, 16'd9);
        send_fraction(OP_ADD, 16'hffff, 16'hfffe, 16'hffff, 16'hfffe);
        send_fraction(OP_SUB, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_fraction(OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_fraction(OP_DIV, 16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0);

        // Long receiver hold-off while the sender keeps offering, to fill the queue.
        hold_off = 300;
        repeat (6)
            send_fraction(2'($urandom), edge_value(), edge_value(), edge_value(), edge_value());
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (burst <= 0)
            begin
                burst = $urandom_range(1, 12);
                idle_sender($urandom_range(0, 300));
            end
            burst--;
            if ($urandom_range(0, 2) == 0)
            begin
                fa = edge_value();
                fb = edge_value();
                fc = edge_value();
                fd = edge_value();
            end
            else
            begin
                fa = 16'($urandom);
                fb = 16'($urandom);
                fc = 16'($urandom);
                fd = 16'($urandom);
            end
            send_fraction(2'($urandom), fa, fb, fc, fd);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
        end
        drain_results();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/rfa_pkg.sv
hdl/rfa_if.sv
hdl/rfa_front.sv
hdl/rfa_queue.sv
hdl/rfa_back.sv
hdl/rational_fraction_alu_top.sv
tb/sv/rfa_checker.sv
tb/sv/testbench.sv
